FILE: hdl/waypoint_trajectory_timer_assert.svh
// Assertion macros for the waypoint trajectory timer.
`ifndef WAYPOINT_TRAJECTORY_TIMER_ASSERT_SVH
`define WAYPOINT_TRAJECTORY_TIMER_ASSERT_SVH
`ifndef SYNTH
`define WTT_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define WTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WTT_ASSERT(lbl, expr, msg)
`define WTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/wtt_pkg.sv
// Shared constants and types of the waypoint trajectory timer.
package wtt_pkg;
	localparam int COORD_W = 32;
	localparam int SPEED_W = 16;
	localparam int TIME_W = 32;
	localparam int GAP_W = 32;
	localparam int ROOT_W = 33;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int NUM_W = 54;
	localparam int DEN_W = SPEED_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [20:0] TIME_SCALE = 21'd2000000;
	localparam logic [GAP_W-1:0] NEAR_THRESHOLD = 32'd26;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_SPAN_RST = 32'd6000000;

	localparam logic [CFG_IDX_W-1:0] REG_POSE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_SPAN = 3'd4;

	typedef struct packed {
		logic done;
		logic [ROOT_W-1:0] root;
	} sqrt_res_t;

	typedef struct packed {
		logic done;
		logic sat;
		logic [TIME_W-1:0] quo;
	} div_res_t;
endpackage

FILE: hdl/wtt_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module wtt_sqrt import wtt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [RAD_W-1:0] radicand,
	output sqrt_res_t res
);
	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.root = root_q;
endmodule

FILE: hdl/wtt_div.sv
// Restoring divider for time steps, one quotient bit per cycle, saturating.
module wtt_div import wtt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_res_t res
);
	localparam int CNT_W = $clog2(TIME_W + 1);
	localparam int HI_W = NUM_W - TIME_W;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [TIME_W-1:0] low_q;
	logic [TIME_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic sat_q;
	logic [DEN_W:0] rem_sh;
	logic overflow;

	always_comb begin
		rem_sh = {rem_q, low_q[TIME_W-1]};
		// quotient reaches 2^32 when the upper part alone holds the divisor
		overflow = (den == '0) || (num[NUM_W-1:TIME_W] >= HI_W'(den));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !overflow;
				done_q <= overflow;
				cnt_q <= CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= overflow;
			den_q <= den;
			rem_q <= num[TIME_W +: DEN_W];
			low_q <= num[TIME_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			low_q <= {low_q[TIME_W-2:0], 1'b0};
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
				quo_q <= {quo_q[TIME_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.sat = sat_q;
	assign res.quo = sat_q ? TIME_MAX : quo_q;
endmodule

FILE: hdl/waypoint_trajectory_timer.sv
// Waypoint trajectory timer: sequencer, shared multiplier and output register.
//
// Waypoints arrive on the s_axis channel, one word each, with tlast marking
// the last waypoint of a list. Timed points leave on m_axis: tdata carries
// x, y and time, tuser carries the pose and saturation flags, tlast marks the
// end of the trajectory. A waypoint far from the vehicle pose at the start of
// a list first yields a pose point at time 0.
// Configuration registers are written via cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle (not enforced); unknown indexes are ignored.
// A later waypoint of a list passes through the differences, the squares, the
// serial square root, the scaling multiply and two serial divisions before the
// next ready, the serial units dominating. A first waypoint far from the pose
// takes one division only; one near it skips the square root and divisions.
// Only one waypoint is in work at a time; s_axis_tready is high while the
// sequencer is idle.
// A finished point sits in the output register while the next waypoint is
// taken; if the receiver stalls, the sequencer waits before loading the next
// point. Waypoints after the horizon is reached are dropped until tlast.
// Reset clears the sequencer, configuration, trajectory state and out_valid_q.
module waypoint_trajectory_timer import wtt_pkg::*; #(
	parameter logic [GAP_W-1:0] NEAR_LIMIT = NEAR_THRESHOLD
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // wp_x, wp_y, wp_speed
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [95:0] m_axis_tdata,   // point_x, point_y, point_time
	output logic [1:0] m_axis_tuser,    // from_pose, time_saturated
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIFF, S_CHK, S_POSE, S_SQX, S_SQY, S_SUM, S_ROOT,
		S_MUL, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_UPD, S_EMIT
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] pose_x_q, pose_y_q;
	logic [SPEED_W-1:0] start_speed_q, end_speed_q;
	logic [TIME_W-1:0] time_span_q;

	logic awaiting_q, draining_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [SPEED_W-1:0] prev_speed_q;
	logic [TIME_W-1:0] prev_time_q, horizon_q;

	logic signed [COORD_W-1:0] in_x_q, in_y_q;
	logic [SPEED_W-1:0] in_v_q;
	logic in_last_q, first_q;
	logic [GAP_W-1:0] dx_q, dy_q;
	logic [RAD_W-1:0] prod_q, acc_q;
	logic [ROOT_W-1:0] d_q;
	logic [TIME_W-1:0] t_q, hq_q;
	logic sat_q, done_q;

	logic out_valid_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;
	logic [TIME_W-1:0] out_time_q;
	logic out_pose_q, out_sat_q, out_last_q;

	logic signed [COORD_W-1:0] base_x, base_y;
	logic signed [COORD_W:0] diff_x, diff_y;
	logic [GAP_W-1:0] abs_x, abs_y;
	logic [ROOT_W-1:0] mul_a, mul_b;
	logic [DEN_W-1:0] plan, spd2, den1, den2;
	logic [TIME_W:0] tsum, hsum;
	logic [TIME_W-1:0] hz;
	logic slot_free, accept, load_out;
	logic sqrt_start, div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	sqrt_res_t sqrt_res;
	div_res_t div_res;

	always_comb begin
		base_x = first_q ? pose_x_q : prev_x_q;
		base_y = first_q ? pose_y_q : prev_y_q;
		diff_x = {base_x[COORD_W-1], base_x} - {in_x_q[COORD_W-1], in_x_q};
		diff_y = {base_y[COORD_W-1], base_y} - {in_y_q[COORD_W-1], in_y_q};
		abs_x = diff_x[COORD_W] ? GAP_W'(-diff_x) : diff_x[GAP_W-1:0];
		abs_y = diff_y[COORD_W] ? GAP_W'(-diff_y) : diff_y[GAP_W-1:0];

		case (state_q)
			S_SQX: begin
				mul_a = ROOT_W'(dx_q);
				mul_b = ROOT_W'(dx_q);
			end
			S_SQY: begin
				mul_a = ROOT_W'(dy_q);
				mul_b = ROOT_W'(dy_q);
			end
			default: begin
				mul_a = d_q;
				mul_b = ROOT_W'(TIME_SCALE);
			end
		endcase

		plan = DEN_W'(start_speed_q) + DEN_W'(end_speed_q);
		spd2 = {first_q ? in_v_q : prev_speed_q, 1'b0};
		den1 = (plan < spd2) ? plan : spd2;
		den2 = DEN_W'(prev_speed_q) + DEN_W'(in_v_q);

		tsum = {1'b0, prev_time_q} + {1'b0, t_q};
		hsum = {1'b0, horizon_q} + {1'b0, hq_q};
		hz = hsum[TIME_W] ? TIME_MAX : hsum[TIME_W-1:0];

		slot_free = !out_valid_q || m_axis_tready;
		load_out = slot_free && ((state_q == S_POSE) || (state_q == S_EMIT));
		accept = s_axis_tvalid && s_axis_tready;
		sqrt_start = (state_q == S_SUM);
		div_start = (state_q == S_DIV1) || (state_q == S_DIV2);
		div_num = prod_q[NUM_W-1:0];
		div_den = (state_q == S_DIV2) ? den2 : den1;
	end

	wtt_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand(acc_q + prod_q),
		.res(sqrt_res)
	);

	wtt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.res(div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pose_x_q <= '0;
			pose_y_q <= '0;
			start_speed_q <= '0;
			end_speed_q <= '0;
			time_span_q <= TIME_SPAN_RST;
			awaiting_q <= 1'b1;
			draining_q <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_speed_q <= '0;
			prev_time_q <= '0;
			horizon_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POSE_X: pose_x_q <= cfg_wdata;
					REG_POSE_Y: pose_y_q <= cfg_wdata;
					REG_START_SPEED: start_speed_q <= cfg_wdata[SPEED_W-1:0];
					REG_END_SPEED: end_speed_q <= cfg_wdata[SPEED_W-1:0];
					REG_TIME_SPAN: time_span_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (draining_q) begin
							// drop until the end of the list, then rearm
							if (s_axis_tlast) begin
								draining_q <= 1'b0;
								awaiting_q <= 1'b1;
							end
						end else begin
							state_q <= S_DIFF;
						end
					end
				end
				S_DIFF: begin
					dx_q <= abs_x;
					dy_q <= abs_y;
					state_q <= S_CHK;
				end
				S_CHK: begin
					done_q <= 1'b0;
					if (first_q) begin
						horizon_q <= '0;
					end
					if (first_q && dx_q <= NEAR_LIMIT && dy_q <= NEAR_LIMIT) begin
						t_q <= '0;
						sat_q <= 1'b0;
						state_q <= S_EMIT;
					end else if (first_q) begin
						state_q <= S_POSE;
					end else begin
						state_q <= S_SQX;
					end
				end
				S_POSE: begin
					if (slot_free) begin
						out_x_q <= pose_x_q;
						out_y_q <= pose_y_q;
						out_time_q <= '0;
						out_pose_q <= 1'b1;
						out_sat_q <= 1'b0;
						out_last_q <= 1'b0;
						state_q <= S_SQX;
					end
				end
				S_SQX: begin
					prod_q <= mul_a * mul_b;
					state_q <= S_SQY;
				end
				S_SQY: begin
					acc_q <= prod_q;
					prod_q <= mul_a * mul_b;
					state_q <= S_SUM;
				end
				S_SUM: state_q <= S_ROOT;
				S_ROOT: begin
					if (sqrt_res.done) begin
						d_q <= sqrt_res.root;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= mul_a * mul_b;
					state_q <= S_DIV1;
				end
				S_DIV1: state_q <= S_DIV1W;
				S_DIV1W: begin
					if (div_res.done) begin
						t_q <= div_res.quo;
						sat_q <= div_res.sat;
						state_q <= first_q ? S_EMIT : S_DIV2;
					end
				end
				S_DIV2: state_q <= S_DIV2W;
				S_DIV2W: begin
					if (div_res.done) begin
						hq_q <= div_res.quo;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (tsum[TIME_W]) begin
						t_q <= TIME_MAX;
						sat_q <= 1'b1;
					end else begin
						t_q <= tsum[TIME_W-1:0];
					end
					horizon_q <= hz;
					done_q <= (hz >= time_span_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_x_q <= in_x_q;
						out_y_q <= in_y_q;
						out_time_q <= t_q;
						out_pose_q <= 1'b0;
						out_sat_q <= sat_q;
						out_last_q <= in_last_q || done_q;
						prev_x_q <= in_x_q;
						prev_y_q <= in_y_q;
						prev_speed_q <= in_v_q;
						prev_time_q <= t_q;
						if (first_q) begin
							awaiting_q <= in_last_q;
						end else if (in_last_q) begin
							awaiting_q <= 1'b1;
						end else if (done_q) begin
							draining_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture the waypoint word
	always_ff @(posedge clk) begin
		if (accept) begin
			in_x_q <= s_axis_tdata[31:0];
			in_y_q <= s_axis_tdata[63:32];
			in_v_q <= s_axis_tdata[79:64];
			in_last_q <= s_axis_tlast;
			first_q <= awaiting_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {out_time_q, out_y_q, out_x_q};
	assign m_axis_tuser = {out_sat_q, out_pose_q};
	assign m_axis_tlast = out_last_q;

`include "waypoint_trajectory_timer_assert.svh"

	`WTT_ASSERT(a_flags_excl, !(draining_q && awaiting_q), "draining while awaiting first")
	`WTT_ASSERT(a_div2_not_first, !(state_q == S_DIV2 && first_q), "horizon on first waypoint")
	`WTT_ASSERT(a_pose_point, !(out_valid_q && out_pose_q) || !(out_last_q || out_sat_q), "pose flags")
	`WTT_ASSERT_NEXT(a_drop, accept && draining_q, state_q == S_IDLE, "dropped word started work")
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the waypoint trajectory timer.
module testbench;
	import wtt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] spd;
		logic last;
	} waypoint_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] t;
		logic pose;
		logic sat;
		logic eot;
	} point_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata;   // wp_x, wp_y, wp_speed
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [95:0] m_axis_tdata;   // point_x, point_y, point_time
	logic [1:0] m_axis_tuser;    // from_pose, time_saturated
	logic m_axis_tlast;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	waypoint_trajectory_timer DUT (.*);

	waypoint_t wp_pending[$];
	point_t points_due[$];
	waypoint_t offered;

	// shadow configuration and trajectory state
	logic [31:0] sh_pose_x, sh_pose_y, sh_span;
	logic [15:0] sh_start, sh_end;
	logic tr_awaiting, tr_draining;
	logic [31:0] tr_px, tr_py, tr_ptime, tr_horizon;
	logic [15:0] tr_pspd;

	int errors, n_words, n_points, n_pose, n_sat, n_eot, cycles;
	int gap_cnt, burst_cnt, rx_run, rx_mode, hold_cnt;
	logic hold_req, hold_done;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [32:0] abs_diff(logic [31:0] a, logic [31:0] b);
		longint d;
		d = longint'($signed(a)) - longint'($signed(b));
		if (d < 0)
			d = -d;
		return d[32:0];
	endfunction

	function automatic logic [33:0] euclid(logic [31:0] ax, logic [31:0] ay,
			logic [31:0] bx, logic [31:0] by);
		logic [32:0] dx, dy;
		logic [67:0] rad, sq;
		logic [33:0] r, c;
		dx = abs_diff(ax, bx);
		dy = abs_diff(ay, by);
		rad = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			sq = 68'(c) * 68'(c);
			if (sq <= rad)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [31:0] scaled_quot(logic [33:0] d, logic [17:0] den,
			inout logic sat);
		logic [63:0] q;
		if (den == 0) begin
			sat = 1;
			return TIME_MAX;
		end
		q = (64'(d) * 64'd2000000) / 64'(den);
		if (q > 64'hFFFF_FFFF) begin
			sat = 1;
			return TIME_MAX;
		end
		return q[31:0];
	endfunction

	function automatic logic [31:0] sum_sat(logic [31:0] a, logic [31:0] b, inout logic sat);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[32]) begin
			sat = 1;
			return TIME_MAX;
		end
		return s[31:0];
	endfunction

	// work out the points one waypoint yields and queue them
	task automatic time_waypoint(waypoint_t w);
		logic [17:0] plan, den;
		logic sat, hsat, done;
		logic [33:0] d;
		logic [31:0] t, hstep;
		point_t p;
		plan = 18'(sh_start) + 18'(sh_end);
		sat = 0;
		hsat = 0;
		if (tr_draining) begin
			if (w.last) begin
				tr_draining = 0;
				tr_awaiting = 1;
			end
			return;
		end
		if (tr_awaiting) begin
			t = 0;
			if (abs_diff(sh_pose_x, w.x) > 33'(NEAR_THRESHOLD) ||
					abs_diff(sh_pose_y, w.y) > 33'(NEAR_THRESHOLD)) begin
				den = 18'(w.spd) << 1;
				if (plan < den)
					den = plan;
				p = '{sh_pose_x, sh_pose_y, 32'd0, 1'b1, 1'b0, 1'b0};
				points_due.insert(points_due.size(), p);
				t = scaled_quot(euclid(sh_pose_x, sh_pose_y, w.x, w.y), den, sat);
			end
			p = '{w.x, w.y, t, 1'b0, sat, w.last};
			points_due.insert(points_due.size(), p);
			tr_ptime = t;
			tr_horizon = 0;
			tr_awaiting = w.last;
		end else begin
			d = euclid(tr_px, tr_py, w.x, w.y);
			den = 18'(tr_pspd) << 1;
			if (plan < den)
				den = plan;
			t = scaled_quot(d, den, sat);
			t = sum_sat(tr_ptime, t, sat);
			hstep = scaled_quot(d, 18'(tr_pspd) + 18'(w.spd), hsat);
			tr_horizon = sum_sat(tr_horizon, hstep, hsat);
			done = tr_horizon >= sh_span;
			p = '{w.x, w.y, t, 1'b0, sat, w.last | done};
			points_due.insert(points_due.size(), p);
			tr_ptime = t;
			if (w.last)
				tr_awaiting = 1;
			else if (done)
				tr_draining = 1;
		end
		tr_px = w.x;
		tr_py = w.y;
		tr_pspd = w.spd;
	endtask

	// driver: bursts of words with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				time_waypoint(offered);
				n_words++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					s_axis_tvalid <= 0;
				end else if (wp_pending.size() > 0) begin
					offered = wp_pending.pop_front();
					s_axis_tdata <= {offered.spd, offered.y, offered.x};
					s_axis_tlast <= offered.last;
					s_axis_tvalid <= 1;
					if (burst_cnt > 0) begin
						burst_cnt--;
					end else begin
						burst_cnt = $urandom_range(0, 20);
						gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
					end
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// receiver: own stall pattern plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_cnt = 3000;
			hold_done = 1;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 0;
		end else begin
			if (rx_run == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_run = (rx_mode == 2) ? $urandom_range(1, 40) : $urandom_range(20, 300);
			end
			rx_run--;
			case (rx_mode)
				0: m_axis_tready <= 1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= 0;
			endcase
		end
	end

	// monitor: compare each word against the oldest predicted point
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (points_due.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h t=%h", $time,
					m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]);
				errors++;
			end else begin
				want = points_due.pop_front();
				n_points++;
				n_pose += want.pose;
				n_sat += want.sat;
				n_eot += want.eot;
				if (want.x !== m_axis_tdata[31:0]) begin
					$display("%0t: point_x expected %h got %h", $time, want.x, m_axis_tdata[31:0]);
					errors++;
				end
				if (want.y !== m_axis_tdata[63:32]) begin
					$display("%0t: point_y expected %h got %h", $time, want.y, m_axis_tdata[63:32]);
					errors++;
				end
				if (want.t !== m_axis_tdata[95:64]) begin
					$display("%0t: point_time expected %h got %h", $time, want.t,
						m_axis_tdata[95:64]);
					errors++;
				end
				if (want.pose !== m_axis_tuser[0]) begin
					$display("%0t: from_pose expected %b got %b", $time, want.pose, m_axis_tuser[0]);
					errors++;
				end
				if (want.sat !== m_axis_tuser[1]) begin
					$display("%0t: time_saturated expected %b got %b", $time, want.sat,
						m_axis_tuser[1]);
					errors++;
				end
				if (want.eot !== m_axis_tlast) begin
					$display("%0t: end_of_trajectory expected %b got %b", $time, want.eot,
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** waypoint_trajectory_timer: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_POSE_X: sh_pose_x = val;
			REG_POSE_Y: sh_pose_y = val;
			REG_START_SPEED: sh_start = val[15:0];
			REG_END_SPEED: sh_end = val[15:0];
			REG_TIME_SPAN: sh_span = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic setup(logic [31:0] px, logic [31:0] py, logic [31:0] ss,
			logic [31:0] es, logic [31:0] span);
		write_reg(REG_POSE_X, px);
		write_reg(REG_POSE_Y, py);
		write_reg(REG_START_SPEED, ss);
		write_reg(REG_END_SPEED, es);
		write_reg(REG_TIME_SPAN, span);
	endtask

	task automatic queue_wp(logic [31:0] x, logic [31:0] y, logic [15:0] v, logic last);
		waypoint_t w;
		w = '{x, y, v, last};
		wp_pending.insert(wp_pending.size(), w);
	endtask

	function automatic logic [15:0] pick_speed();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return 16'($urandom);
		return 16'($urandom_range(128, 4000));
	endfunction

	// well-formed lists with random content, mixed with random noise words
	task automatic queue_random(int count);
		logic [31:0] x, y;
		int n;
		while (count > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_wp($urandom, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
				count--;
			end else begin
				n = $urandom_range(1, 8);
				if ($urandom_range(0, 1)) begin
					x = sh_pose_x + $signed($urandom_range(0, 52)) - 26;
					y = sh_pose_y + $signed($urandom_range(0, 52)) - 26;
				end else begin
					x = sh_pose_x + $signed($urandom_range(0, 8000)) - 4000;
					y = sh_pose_y + $signed($urandom_range(0, 8000)) - 4000;
				end
				for (int i = 0; i < n; i++) begin
					queue_wp(x, y, pick_speed(), i == n - 1);
					x = x + $signed($urandom_range(0, 4000)) - 2000;
					y = y + $signed($urandom_range(0, 4000)) - 2000;
				end
				count -= n;
			end
		end
	endtask

	task automatic wait_idle();
		while (wp_pending.size() > 0 || s_axis_tvalid || points_due.size() > 0)
			@(posedge clk);
		// dropped words leave nothing to wait for; let the sequencer settle
		repeat (150) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		n_words = 0;
		n_points = 0;
		n_pose = 0;
		n_sat = 0;
		n_eot = 0;
		cycles = 0;
		gap_cnt = 0;
		burst_cnt = 0;
		rx_run = 0;
		rx_mode = 0;
		hold_cnt = 0;
		hold_req = 0;
		hold_done = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		sh_pose_x = 0;
		sh_pose_y = 0;
		sh_start = 0;
		sh_end = 0;
		sh_span = TIME_SPAN_RST;
		tr_awaiting = 1;
		tr_draining = 0;
		tr_px = 0;
		tr_py = 0;
		tr_pspd = 0;
		tr_ptime = 0;
		tr_horizon = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: plan speed zero saturates every far first point
		queue_wp(32'd10, 32'd5, 16'd1000, 1);
		queue_wp(32'd5000, 32'd0, 16'd1000, 1);
		queue_wp(32'd0, 32'd0, 16'd500, 0);
		queue_wp(32'd300, 32'd400, 16'd500, 1);
		wait_idle();

		setup(32'd0, 32'd0, 32'd512, 32'd1024, 32'd6000000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		queue_wp(32'd26, 32'hFFFF_FFE6, 16'd256, 1);
		queue_wp(32'd27, 32'd0, 16'd256, 1);
		queue_wp(32'd0, 32'd0, 16'd0, 0);
		queue_wp(32'd0, 32'd0, 16'd0, 0);
		queue_wp(32'd1000, 32'd1000, 16'd700, 1);
		queue_wp(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 0);
		queue_wp(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1);
		queue_wp(32'd0, 32'd0, 16'd1024, 0);
		for (int i = 1; i <= 6; i++)
			queue_wp(32'(i * 2000), 32'(i * 1500), 16'd1024, 0);
		queue_wp(32'd50000, 32'd50000, 16'd1024, 1);
		queue_wp(32'd0, 32'd0, 16'd800, 1);
		wait_idle();
		queue_random(200);
		wait_idle();

		setup(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
		hold_req <= 1;
		queue_random(200);
		wait_idle();

		setup($urandom_range(0, 100000), 32'hFFFF_0000, 32'd0, 32'd0, 32'd0);
		queue_random(150);
		wait_idle();

		setup(32'hFFFF_F000, $urandom_range(0, 5000), $urandom_range(0, 3000),
			$urandom_range(0, 3000), 32'd2000000);
		queue_random(250);
		wait_idle();

		$display("%0d waypoints taken, %0d points checked (%0d pose, %0d saturated, %0d ends)",
			n_words, n_points, n_pose, n_sat, n_eot);
		$display("five register settings covered, one long receiver hold-off");
		if (errors == 0) begin
			$display("** waypoint_trajectory_timer: PASSED **");
		end else begin
			$display("** waypoint_trajectory_timer: FAILED **");
		end
		$finish;
	end
endmodule
